// ===== src/bed_pkg.sv =====
package bed_pkg;

  localparam int unsigned MAX_RESULTS = 4;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int unsigned IDX_W       = $clog2(MAX_RESULTS);

  // Configuration register indexes
  localparam logic CFG_ESCAPES_ON      = 1'b0;
  localparam logic CFG_TRAILING_NEWLINE = 1'b1;

  // Character codes
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_LC    = 8'h63;
  localparam logic [7:0] CH_LE    = 8'h65;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LN    = 8'h6E;
  localparam logic [7:0] CH_LR    = 8'h72;
  localparam logic [7:0] CH_LT    = 8'h74;
  localparam logic [7:0] CH_LV    = 8'h76;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_BSL  = 5'b00010,
    PH_HEX0 = 5'b00100,
    PH_HEX1 = 5'b01000,
    PH_OCT  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [CNT_W-1:0]            cnt;
  } emit_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // Append one byte unless output is stopped or all MAX_RESULTS slots are full
  function automatic emit_t emit_byte(input emit_t em, input logic stopped,
                                      input logic [7:0] b);
    emit_t res;
    res = em;
    if (!stopped && (em.cnt < CNT_W'(MAX_RESULTS))) begin
      res.bytes[em.cnt[IDX_W-1:0]] = b;
      res.cnt = em.cnt + CNT_W'(1);
    end
    return res;
  endfunction

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t   res;
    logic [7:0] d;
    res = '0;
    if (c >= CH_0 && c <= CH_9) begin
      d = c - CH_0;
      res = '{ok: 1'b1, val: d[3:0]};
    end else if (c >= CH_LA && c <= CH_LF) begin
      d = c - CH_LA + 8'd10;
      res = '{ok: 1'b1, val: d[3:0]};
    end else if (c >= CH_UA && c <= CH_UF) begin
      d = c - CH_UA + 8'd10;
      res = '{ok: 1'b1, val: d[3:0]};
    end
    return res;
  endfunction

endpackage

// ===== src/backslash_escape_decoder.sv =====
// Echo-style argument text decoder. Each input transaction carries at most
// one text byte plus end-of-argument and last-argument marks; it is decoded
// in the cycle it is accepted and yields zero to four output bytes, which
// leave one per cycle while out_ready is high, from a small result buffer
// (out_run_last marks the final byte of each input transaction). A new
// input transaction is taken in the same cycle the last buffered byte is
// taken, so plain text flows at one byte per cycle while out_ready is
// high; an input waits for the previous one's last byte, if any. With
// escapes_on set, backslash escapes are decoded (\a \b \e \f \n \r \t \v,
// \\, \xH[H], octal \0NNN and \N[N[N]], \c stops output until the last
// argument ends). A space goes between arguments and, with trailing_newline
// set, a newline after the last one. Write configuration only while idle.
module backslash_escape_decoder
  import bed_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // configuration
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic       cfg_wdata,
  // input transactions
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_has_byte,
  input  logic [7:0] in_text_byte,
  input  logic       in_arg_end,
  input  logic       in_final_arg,
  // result transactions
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_halted
);

  logic                        escapes_on_r;
  logic                        trailing_newline_r;

  phase_t                      phase_r, phase_nxt;
  logic [7:0]                  value_r, value_nxt;
  logic [1:0]                  digits_r, digits_nxt;
  logic                        stop_r, stop_nxt;

  logic [MAX_RESULTS-1:0][7:0] bytes_r;
  logic [CNT_W-1:0]            count_r;
  logic [IDX_W-1:0]            rd_r;

  emit_t                       em;
  hex_t                        hx;
  logic                        do_idle;
  logic                        in_fire, out_fire;
  logic [7:0]                  c;

  // Result buffer: count_r bytes remain, rd_r points at the next one
  assign out_valid    = (count_r != '0);
  assign out_byte     = bytes_r[rd_r];
  assign out_run_last = (count_r == CNT_W'(1));
  // Bytes are only ever produced while output runs, so this reads low
  assign out_halted   = 1'b0;

  assign out_fire = out_valid && out_ready;
  assign in_ready = (count_r == '0) || (out_run_last && out_ready);
  assign in_fire  = in_valid && in_ready;
  assign c        = in_text_byte;

  // Decode one input transaction against the current escape state
  always_comb begin
    phase_nxt  = phase_r;
    value_nxt  = value_r;
    digits_nxt = digits_r;
    stop_nxt   = stop_r;
    em         = '0;
    hx         = hex_digit(c);
    do_idle    = 1'b0;

    if (in_has_byte) begin
      unique case (phase_r)
        PH_BSL: begin
          phase_nxt = PH_IDLE;
          case (c)
            CH_LA:  em = emit_byte(em, stop_nxt, CH_BEL);
            CH_LB:  em = emit_byte(em, stop_nxt, CH_BS);
            CH_LE:  em = emit_byte(em, stop_nxt, CH_ESC);
            CH_LF:  em = emit_byte(em, stop_nxt, CH_FF);
            CH_LN:  em = emit_byte(em, stop_nxt, CH_NL);
            CH_LR:  em = emit_byte(em, stop_nxt, CH_CR);
            CH_LT:  em = emit_byte(em, stop_nxt, CH_TAB);
            CH_LV:  em = emit_byte(em, stop_nxt, CH_VT);
            CH_BSL: em = emit_byte(em, stop_nxt, CH_BSL);
            CH_LC:  stop_nxt = 1'b1;
            CH_LX:  phase_nxt = PH_HEX0;
            CH_0: begin
              value_nxt  = '0;
              digits_nxt = 2'd3;
              phase_nxt  = PH_OCT;
            end
            default: begin
              if (c >= CH_1 && c <= CH_7) begin
                value_nxt  = {5'd0, c[2:0]};
                digits_nxt = 2'd2;
                phase_nxt  = PH_OCT;
              end else begin
                em = emit_byte(em, stop_nxt, CH_BSL);
                em = emit_byte(em, stop_nxt, c);
              end
            end
          endcase
        end
        PH_HEX0: begin
          if (hx.ok) begin
            value_nxt = {4'd0, hx.val};
            phase_nxt = PH_HEX1;
          end else begin
            em      = emit_byte(em, stop_nxt, CH_BSL);
            em      = emit_byte(em, stop_nxt, CH_LX);
            do_idle = 1'b1;
          end
        end
        PH_HEX1: begin
          if (hx.ok) begin
            em        = emit_byte(em, stop_nxt, {value_r[3:0], hx.val});
            phase_nxt = PH_IDLE;
          end else begin
            em      = emit_byte(em, stop_nxt, value_r);
            do_idle = 1'b1;
          end
        end
        PH_OCT: begin
          if (c >= CH_0 && c <= CH_7) begin
            value_nxt  = {value_r[4:0], c[2:0]};
            digits_nxt = digits_r - 2'd1;
            if (digits_nxt == 2'd0) begin
              em        = emit_byte(em, stop_nxt, value_nxt);
              phase_nxt = PH_IDLE;
            end
          end else begin
            em      = emit_byte(em, stop_nxt, value_r);
            do_idle = 1'b1;
          end
        end
        default: do_idle = 1'b1;
      endcase

      // Plain character handling, also for a byte that ends an escape early
      if (do_idle) begin
        phase_nxt = PH_IDLE;
        if (escapes_on_r && (c == CH_BSL)) begin
          phase_nxt = PH_BSL;
        end else begin
          em = emit_byte(em, stop_nxt, c);
        end
      end
    end

    if (in_arg_end) begin
      // Flush whatever escape is still open
      unique case (phase_nxt)
        PH_BSL:  em = emit_byte(em, stop_nxt, CH_BSL);
        PH_HEX0: begin
          em = emit_byte(em, stop_nxt, CH_BSL);
          em = emit_byte(em, stop_nxt, CH_LX);
        end
        PH_HEX1: em = emit_byte(em, stop_nxt, value_nxt);
        PH_OCT:  em = emit_byte(em, stop_nxt, value_nxt);
        default: ;
      endcase
      phase_nxt = PH_IDLE;
      if (in_final_arg) begin
        if (trailing_newline_r) begin
          em = emit_byte(em, stop_nxt, CH_NL);
        end
        stop_nxt = 1'b0;
      end else begin
        em = emit_byte(em, stop_nxt, CH_SPACE);
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escapes_on_r       <= 1'b0;
      trailing_newline_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ESCAPES_ON:       escapes_on_r       <= cfg_wdata;
        CFG_TRAILING_NEWLINE: trailing_newline_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Escape state: advance on every accepted input transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      value_r  <= '0;
      digits_r <= '0;
      stop_r   <= 1'b0;
    end else if (in_fire) begin
      phase_r  <= phase_nxt;
      value_r  <= value_nxt;
      digits_r <= digits_nxt;
      stop_r   <= stop_nxt;
    end
  end

  // Result buffer control: load on accept, otherwise drop the taken byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rd_r    <= '0;
    end else if (in_fire) begin
      count_r <= em.cnt;
      rd_r    <= '0;
    end else if (out_fire) begin
      count_r <= count_r - CNT_W'(1);
      rd_r    <= rd_r + IDX_W'(1);
    end
  end

  // Result payload: hold until the next accepted transaction
  always_ff @(posedge clk) begin
    if (in_fire) begin
      bytes_r <= em.bytes;
    end
  end

endmodule

// ===== sim/bed_checker.sv =====
module bed_checker
  import bed_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_has_byte,
  input  logic [7:0]  in_text_byte,
  input  logic        in_arg_end,
  input  logic        in_final_arg,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte,
  input  logic        out_run_last,
  input  logic        out_halted,
  output int unsigned err_count,
  output int unsigned owed
);

  localparam int unsigned MAX_REPORTS = 50;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       halted;
  } text_out_t;

  text_out_t  decoded_q[$];

  // decoder state as the block should hold it
  logic       esc_en;
  logic       nl_en;
  phase_t     phase;
  logic [7:0] acc;
  logic [1:0] oct_left;
  logic       silenced;

  // bytes produced by the transaction being decoded
  logic [7:0] run_bytes [MAX_RESULTS];
  int         run_len;

  function automatic void put_byte(input logic [7:0] b);
    if (!silenced && run_len < MAX_RESULTS) begin
      run_bytes[run_len] = b;
      run_len++;
    end
  endfunction

  function automatic int nibble_of(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
    if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
    return -1;
  endfunction

  function automatic void take_plain(input logic [7:0] c);
    phase = PH_IDLE;
    if (esc_en && c == CH_BSL) begin
      phase = PH_BSL;
    end else begin
      put_byte(c);
    end
  endfunction

  function automatic void take_escape(input logic [7:0] c);
    phase = PH_IDLE;
    case (c)
      CH_LA:  put_byte(CH_BEL);
      CH_LB:  put_byte(CH_BS);
      CH_LE:  put_byte(CH_ESC);
      CH_LF:  put_byte(CH_FF);
      CH_LN:  put_byte(CH_NL);
      CH_LR:  put_byte(CH_CR);
      CH_LT:  put_byte(CH_TAB);
      CH_LV:  put_byte(CH_VT);
      CH_BSL: put_byte(CH_BSL);
      CH_LC:  silenced = 1'b1;
      CH_LX:  phase = PH_HEX0;
      CH_0: begin
        acc = '0;
        oct_left = 2'd3;
        phase = PH_OCT;
      end
      default: begin
        if (c >= CH_1 && c <= CH_7) begin
          acc = c - CH_0;
          oct_left = 2'd2;
          phase = PH_OCT;
        end else begin
          put_byte(CH_BSL);
          put_byte(c);
        end
      end
    endcase
  endfunction

  function automatic void take_byte(input logic [7:0] c);
    int nib;
    nib = nibble_of(c);
    case (phase)
      PH_BSL: take_escape(c);
      PH_HEX0: begin
        if (nib >= 0) begin
          acc = 8'(nib);
          phase = PH_HEX1;
        end else begin
          put_byte(CH_BSL);
          put_byte(CH_LX);
          take_plain(c);
        end
      end
      PH_HEX1: begin
        if (nib >= 0) begin
          put_byte(8'(acc * 16 + nib));
          phase = PH_IDLE;
        end else begin
          put_byte(acc);
          take_plain(c);
        end
      end
      PH_OCT: begin
        if (c >= CH_0 && c <= CH_7) begin
          acc = 8'(acc * 8 + (c - CH_0));
          oct_left = oct_left - 2'd1;
          if (oct_left == 2'd0) begin
            put_byte(acc);
            phase = PH_IDLE;
          end
        end else begin
          put_byte(acc);
          take_plain(c);
        end
      end
      default: take_plain(c);
    endcase
  endfunction

  // finish an escape left open at the end of an argument
  function automatic void close_escape();
    case (phase)
      PH_BSL: put_byte(CH_BSL);
      PH_HEX0: begin
        put_byte(CH_BSL);
        put_byte(CH_LX);
      end
      PH_HEX1, PH_OCT: put_byte(acc);
      default: ;
    endcase
    phase = PH_IDLE;
  endfunction

  function automatic void decode_transaction(input logic has, input logic [7:0] c,
                                             input logic ends, input logic last_arg);
    int k;
    run_len = 0;
    if (has) take_byte(c);
    if (ends) begin
      close_escape();
      if (last_arg) begin
        if (nl_en) put_byte(CH_NL);
        silenced = 1'b0;
      end else begin
        put_byte(CH_SPACE);
      end
    end
    for (k = 0; k < run_len; k++) begin
      decoded_q.push_back(text_out_t'{data: run_bytes[k], run_last: (k == run_len - 1),
                                      halted: 1'b0});
    end
  endfunction

  function automatic void check_field(input string field, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      err_count++;
      if (err_count <= MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %02h, actual %02h", $time, field, want, got);
      end
    end
  endfunction

  always @(posedge clk) begin
    text_out_t want;
    if (!rst_n) begin
      esc_en = 1'b0;
      nl_en = 1'b1;
      phase = PH_IDLE;
      acc = '0;
      oct_left = '0;
      silenced = 1'b0;
      decoded_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_ESCAPES_ON) begin
          esc_en = cfg_wdata;
        end else begin
          nl_en = cfg_wdata;
        end
      end
      if (in_valid && in_ready) begin
        decode_transaction(in_has_byte, in_text_byte, in_arg_end, in_final_arg);
      end
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS) begin
            $display("%0t: unexpected result, expected none, actual %02h", $time, out_byte);
          end
        end else begin
          want = decoded_q.pop_front();
          check_field("out_byte", want.data, out_byte);
          check_field("out_run_last", 8'(want.run_last), 8'(out_run_last));
          check_field("out_halted", 8'(want.halted), 8'(out_halted));
        end
      end
    end
    owed = decoded_q.size();
  end

endmodule

// ===== sim/testbench.sv =====
module testbench;
  import bed_pkg::*;

  // Cycles without any transaction on either channel before the run is abandoned.
  localparam int unsigned STALL_LIMIT   = 2000;
  // Settle time after the last result: the decoder works in the accepting cycle.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned IDLE_PAUSE    = 4;
  localparam int unsigned RANDOM_ITEMS  = 350;
  localparam int unsigned NUM_PHASES    = 5;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic        cfg_wdata = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_has_byte = 1'b0;
  logic [7:0]  in_text_byte = 8'h00;
  logic        in_arg_end = 1'b0;
  logic        in_final_arg = 1'b0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        out_run_last;
  logic        out_halted;

  int unsigned err_count;
  int unsigned owed;

  int unsigned idle_cycles = 0;
  logic [15:0] rx_tick = '0;
  int unsigned burst_left = 0;
  int unsigned items_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  backslash_escape_decoder i_dut (.*);

  bed_checker i_check (.*);

  // Receiver: cycle through four windows, picked by rx_tick[8:7] - always ready, mostly
  // ready, a fixed two-of-five pattern, and coin flips.
  always @(posedge clk) begin
    rx_tick <= rx_tick + 16'd1;
    case (rx_tick[8:7])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= ($urandom_range(0, 3) != 0);
      2'd2: out_ready <= ((rx_tick % 16'd5) < 16'd2);
      default: out_ready <= 1'($urandom_range(0, 1));
    endcase
  end

  // Watchdog: abort when neither channel has moved a transaction for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Offer one input transaction and hold it until accepted. Bursts of random
  // length are separated by random gaps; some gaps are zero so back-to-back
  // stretches occur. Entered and left in the time step of a rising edge.
  task automatic send_item(input logic has, input logic [7:0] c, input logic ends,
                           input logic last_arg);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_has_byte <= has;
    in_text_byte <= c;
    in_arg_end <= ends;
    in_final_arg <= last_arg;
    // sample ready mid-cycle, where nothing is changing
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  // Send a string as text bytes; the end marks ride on the last byte.
  task automatic send_text(input string s, input logic ends, input logic last_arg);
    int i;
    for (i = 0; i < s.len(); i++) begin
      send_item(1'b1, s[i], (i == s.len() - 1) ? ends : 1'b0,
                (i == s.len() - 1) ? last_arg : 1'b0);
    end
  endtask

  // Drop valid and hold off until every expected byte has arrived, then give
  // the decoder a few cycles in case the last transaction produced nothing.
  task automatic drain_results(input int unsigned settle);
    in_valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (owed != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] named_escape(input int unsigned k);
    case (k)
      0: return CH_LA;
      1: return CH_LB;
      2: return CH_LE;
      3: return CH_LF;
      4: return CH_LN;
      5: return CH_LR;
      6: return CH_LT;
      7: return CH_LV;
      default: return CH_BSL;
    endcase
  endfunction

  function automatic logic [7:0] random_hex_char();
    int unsigned v;
    v = $urandom_range(0, 21);
    if (v < 10) return CH_0 + 8'(v);
    if (v < 16) return CH_LA + 8'(v - 10);
    return CH_UA + 8'(v - 16);
  endfunction

  // One random token: mostly well-formed escapes with random content, plus
  // plain bytes, unknown escapes, empty arguments and do-nothing transactions.
  task automatic send_random_token();
    logic [7:0]  seq[$];
    int unsigned n;
    int unsigned i;
    logic        forced;
    logic        ends;
    logic        last_arg;
    logic        split;
    forced = 1'b0;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5: seq.push_back(8'($urandom_range(0, 255)));
      6, 7, 8: begin
        seq.push_back(CH_BSL);
        seq.push_back(named_escape($urandom_range(0, 8)));
      end
      9: begin
        // stop escape, kept rare so output is not silenced too often
        seq.push_back(CH_BSL);
        seq.push_back(($urandom_range(0, 2) == 0) ? CH_LC : CH_BSL);
      end
      10, 11, 12: begin
        seq.push_back(CH_BSL);
        seq.push_back(CH_LX);
        n = $urandom_range(0, 2);
        repeat (n) seq.push_back(random_hex_char());
        if ($urandom_range(0, 1) == 0) seq.push_back(8'($urandom_range(0, 255)));
      end
      13, 14, 15: begin
        seq.push_back(CH_BSL);
        seq.push_back(8'($urandom_range(CH_0, CH_7)));
        n = $urandom_range(0, 3);
        repeat (n) seq.push_back(8'($urandom_range(CH_0, CH_7)));
        if ($urandom_range(0, 1) == 0) seq.push_back(8'($urandom_range(0, 255)));
      end
      16: begin
        seq.push_back(CH_BSL);
        seq.push_back(8'($urandom_range(0, 255)));
      end
      17: begin
        // backslash closing an argument
        seq.push_back(CH_BSL);
        forced = 1'b1;
      end
      18: forced = 1'b1;
      default: begin
        // no byte, no end mark: ignored by the block
        send_item(1'b0, 8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
        items_sent++;
        return;
      end
    endcase
    ends = forced || ($urandom_range(0, 4) == 0);
    last_arg = ends && ($urandom_range(0, 2) == 0);
    split = ends && (seq.size() != 0) && ($urandom_range(0, 3) == 0);
    for (i = 0; i < seq.size(); i++) begin
      if (i == seq.size() - 1 && ends && !split) begin
        send_item(1'b1, seq[i], 1'b1, last_arg);
      end else begin
        send_item(1'b1, seq[i], 1'b0, 1'($urandom_range(0, 1)));
      end
      items_sent++;
    end
    // carry the end mark on a transaction of its own
    if (seq.size() == 0 || split) begin
      send_item(1'b0, 8'($urandom_range(0, 255)), 1'b1, last_arg);
      items_sent++;
    end
  endtask

  initial begin
    logic [1:0] phase_cfg;
    int unsigned p;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, escapes on, newline at the end.
    write_reg(CFG_ESCAPES_ON, 1'b1);
    // named control, unknown escape, hex cut short by a new escape, octal
    // with three digits in all truncated to a byte, then a space
    send_text("\\n\\q\\x4\\777", 1'b1, 1'b0);
    // \0 followed by three octal digits
    send_text("\\0101", 1'b0, 1'b0);
    // backslash at the end of an argument
    send_text("\\", 1'b1, 1'b0);
    send_item(1'b0, 8'hFF, 1'b0, 1'b1);
    // empty argument
    send_item(1'b0, 8'h00, 1'b1, 1'b0);
    // stop output; the last argument ends silently and clears the stop
    send_text("\\cA", 1'b0, 1'b0);
    send_text("B", 1'b1, 1'b1);
    // leave a hex escape open, switch escapes off while idle: the pending
    // escape still completes, the next backslash passes through
    send_text("\\x4", 1'b0, 1'b0);
    drain_results(IDLE_PAUSE);
    write_reg(CFG_ESCAPES_ON, 1'b0);
    send_text("1\\", 1'b1, 1'b1);

    // Random part: walk through register settings, extremes included.
    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: phase_cfg = 2'b11;
        1: phase_cfg = 2'b10;
        2: phase_cfg = 2'b00;
        3: phase_cfg = 2'b01;
        default: phase_cfg = 2'b11;
      endcase
      drain_results(IDLE_PAUSE);
      write_reg(CFG_ESCAPES_ON, phase_cfg[1]);
      write_reg(CFG_TRAILING_NEWLINE, phase_cfg[0]);
      while (items_sent < (p + 1) * RANDOM_ITEMS / NUM_PHASES) begin
        send_random_token();
        // occasionally hold the sender until the output side is empty
        if ($urandom_range(0, 59) == 0) drain_results(IDLE_PAUSE);
      end
    end

    drain_results(SETTLE_CYCLES);
    if (err_count == 0 && owed == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
